>>> rtl/vpc_pkg.sv
// ----------------------------------------------------------------------------
// vpc_pkg
// Shared types and constants of the variant picker with cooldown.
// ----------------------------------------------------------------------------
package vpc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  // loop counters, cursor and entry count
  localparam int CW      = 6;
  // configuration register index
  localparam int CFG_IW  = 8;
  // running weight sums
  localparam int SUM_W   = 22;

  localparam logic [63:0] RNG_DEFAULT = 64'h0000_0000_00D7_E130;
  localparam logic [63:0] RNG_MUL     = 64'd2685821657736338717;

  typedef logic [1:0] status_t;
  localparam status_t ST_CHOSEN = 2'd0;
  localparam status_t ST_NONE   = 2'd1;
  localparam status_t ST_LOADED = 2'd2;

  localparam logic [1:0] MODE_SEQ     = 2'd0;
  localparam logic [1:0] MODE_SHUFFLE = 2'd1;

  localparam logic [CFG_IW-1:0] CFG_PICK_MODE   = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_NO_REPEAT   = 8'd1;
  localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 8'd2;
  localparam logic [CFG_IW-1:0] CFG_SEED        = 8'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EL_RD,
    S_EL_CHK,
    S_DISP,
    S_SEQ,
    S_DRAW,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_DIV,
    S_SW_RA,
    S_SW_RB,
    S_SW_WA,
    S_SW_WB,
    S_SP_RD,
    S_SP_CHK,
    S_WT_M0,
    S_WT_M1,
    S_WT_M2,
    S_WT_RD,
    S_WT_CHK,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT
  } state_t;

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage

>>> rtl/vpc_ram.sv
// ----------------------------------------------------------------------------
// vpc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/variant_picker_with_cooldown.sv
// ----------------------------------------------------------------------------
// variant_picker_with_cooldown
// Picks one variant entry per trigger in sequence, shuffle or weighted mode.
// ----------------------------------------------------------------------------
// A load request writes one entry whose index is in range. A trigger scans
// the table (one RAM read and check per entry in use), then picks: sequence
// mode walks eligibility flags one entry a cycle; weighted mode draws once on
// the shared 32x32 multiplier, scales the draw by the weight total and rescans
// weights; a shuffle costs per swap one draw, a bit-serial modulo and two
// order RAM reads and two writes, plus one order RAM read per order entry tried.
// A dispatch step precedes the pick; the cooldown update and the output handoff
// follow it. in_stall is high from acceptance until the result is handed to
// the output register, so one request is in work at a time.
module variant_picker_with_cooldown #(
  parameter int MAX_ENTRIES = vpc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [3:0]                in_entry_index,
  input  logic [15:0]               in_entry_weight,
  input  logic [31:0]               in_entry_cooldown,
  input  logic [63:0]               in_frame,
  output logic                      out_valid,
  input  logic                      out_stall,
  output vpc_pkg::status_t          out_status,
  output logic [3:0]                out_chosen_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [vpc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]               cfg_data
);
  import vpc_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);

  state_t state_r, state_nxt;

  logic [1:0]        mode_r, mode_nxt;
  logic              norep_r, norep_nxt;
  logic [4:0]        ecnt_r, ecnt_nxt;
  logic [63:0]       rng_r, rng_nxt;

  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     shi_r, shi_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [5:0]        dbit_r, dbit_nxt;
  logic [63:0]       frame_r, frame_nxt;
  logic [63:0]       rand_r, rand_nxt;
  logic [63:0]       prod_r;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]  target_r, target_nxt;
  logic [SUM_W-1:0]  run_r, run_nxt;
  logic [31:0]       plohi_r, plohi_nxt;
  logic              any_r, any_nxt;
  logic [IW-1:0]     first_r, first_nxt;
  logic [IW-1:0]     chosen_r, chosen_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [IW-1:0]     swa_r, swa_nxt;
  status_t           status_r, status_nxt;
  logic [IW-1:0]     last_r, last_nxt;
  logic              last_vld_r, last_vld_nxt;
  logic [MAX_ENTRIES-1:0] elig_r, elig_nxt;
  logic [MAX_ENTRIES-1:0] na_vld_r, na_vld_nxt;
  logic [MAX_ENTRIES-1:0] ord_vld_r, ord_vld_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [3:0]        out_idx_r, out_idx_nxt;

  logic [31:0]       mul_a, mul_b;

  // entry RAM holds {cooldown, weight}
  logic              ent_we;
  logic [IW-1:0]     ent_waddr, ent_raddr;
  logic [47:0]       ent_wdata, ent_rdata;
  logic              na_we;
  logic [IW-1:0]     na_waddr, na_raddr;
  logic [63:0]       na_wdata, na_rdata;
  logic              ord_we;
  logic [IW-1:0]     ord_waddr, ord_raddr;
  logic [IW-1:0]     ord_wdata, ord_rdata;

  logic [CW-1:0]     n_w;
  logic [63:0]       na_val;
  logic              ok_w;
  logic [6:0]        rem_sh;
  logic [IW-1:0]     ov_w;
  logic [SUM_W-1:0]  run_sum;
  logic [64:0]       upd_sum;
  logic [64:0]       tgt_sum;
  logic [CW-1:0]     c_inc;
  logic [CW-1:0]     cur_mod;

  vpc_ram #(.WIDTH(48), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  vpc_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_na_ram (
    .clk(clk), .we(na_we), .waddr(na_waddr), .wdata(na_wdata),
    .raddr(na_raddr), .rdata(na_rdata)
  );

  vpc_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_index = out_idx_r;

  // entries in use, clamped to 1..MAX_ENTRIES
  always_comb begin
    if (ecnt_r == 5'd0) begin
      n_w = CW'(1);
    end else if (7'(ecnt_r) > 7'(MAX_ENTRIES)) begin
      n_w = CW'(MAX_ENTRIES);
    end else begin
      n_w = CW'(ecnt_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_SEQ;
      norep_r     <= 1'b0;
      ecnt_r      <= 5'd1;
      rng_r       <= RNG_DEFAULT;
      cur_r       <= '0;
      last_vld_r  <= 1'b0;
      na_vld_r    <= '0;
      ord_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      norep_r     <= norep_nxt;
      ecnt_r      <= ecnt_nxt;
      rng_r       <= rng_nxt;
      cur_r       <= cur_nxt;
      last_vld_r  <= last_vld_nxt;
      na_vld_r    <= na_vld_nxt;
      ord_vld_r   <= ord_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    c_r          <= c_nxt;
    shi_r        <= shi_nxt;
    rem_r        <= rem_nxt;
    dbit_r       <= dbit_nxt;
    frame_r      <= frame_nxt;
    rand_r       <= rand_nxt;
    total_r      <= total_nxt;
    target_r     <= target_nxt;
    run_r        <= run_nxt;
    plohi_r      <= plohi_nxt;
    any_r        <= any_nxt;
    first_r      <= first_nxt;
    chosen_r     <= chosen_nxt;
    j_r          <= j_nxt;
    swa_r        <= swa_nxt;
    status_r     <= status_nxt;
    last_r       <= last_nxt;
    elig_r       <= elig_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    norep_nxt      = norep_r;
    ecnt_nxt       = ecnt_r;
    rng_nxt        = rng_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    cur_nxt        = cur_r;
    shi_nxt        = shi_r;
    rem_nxt        = rem_r;
    dbit_nxt       = dbit_r;
    frame_nxt      = frame_r;
    rand_nxt       = rand_r;
    total_nxt      = total_r;
    target_nxt     = target_r;
    run_nxt        = run_r;
    plohi_nxt      = plohi_r;
    any_nxt        = any_r;
    first_nxt      = first_r;
    chosen_nxt     = chosen_r;
    j_nxt          = j_r;
    swa_nxt        = swa_r;
    status_nxt     = status_r;
    last_nxt       = last_r;
    last_vld_nxt   = last_vld_r;
    elig_nxt       = elig_r;
    na_vld_nxt     = na_vld_r;
    ord_vld_nxt    = ord_vld_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;

    mul_a     = rng_r[31:0];
    mul_b     = RNG_MUL[31:0];
    ent_we    = 1'b0;
    ent_waddr = IW'(in_entry_index);
    ent_wdata = {in_entry_cooldown, in_entry_weight};
    ent_raddr = IW'(k_r);
    na_we     = 1'b0;
    na_waddr  = chosen_r;
    na_wdata  = '0;
    na_raddr  = IW'(k_r);
    ord_we    = 1'b0;
    ord_waddr = IW'(shi_r - CW'(1));
    ord_wdata = ord_rdata;
    ord_raddr = IW'(shi_r - CW'(1));

    na_val  = na_vld_r[IW'(k_r)] ? na_rdata : 64'd0;
    ok_w    = (frame_r >= na_val) &&
              !(norep_r && (n_w > CW'(1)) && last_vld_r && (last_r == IW'(k_r)));
    rem_sh  = {rem_r, rand_r[dbit_r]};
    ov_w    = ord_vld_r[IW'(c_r)] ? ord_rdata : IW'(c_r);
    run_sum = run_r + SUM_W'(ent_rdata[15:0]);
    upd_sum = {1'b0, frame_r} + 65'(ent_rdata[47:16]);
    tgt_sum = 65'(prod_r) + 65'(plohi_r);
    c_inc   = (c_r + CW'(1) == n_w) ? CW'(0) : c_r + CW'(1);
    cur_mod = (cur_r >= n_w) ? cur_r - n_w : cur_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_action) begin
            if (7'(in_entry_index) < 7'(MAX_ENTRIES)) begin
              ent_we = 1'b1;
            end
            status_nxt = ST_LOADED;
            state_nxt  = S_OUT;
          end else begin
            frame_nxt = in_frame;
            k_nxt     = '0;
            any_nxt   = 1'b0;
            total_nxt = '0;
            first_nxt = '0;
            state_nxt = S_EL_RD;
          end
        end
      end
      S_EL_RD: begin
        state_nxt = S_EL_CHK;
      end
      S_EL_CHK: begin
        elig_nxt[IW'(k_r)] = ok_w;
        if (ok_w) begin
          total_nxt = total_r + SUM_W'(ent_rdata[15:0]);
          if (!any_r) begin
            any_nxt   = 1'b1;
            first_nxt = IW'(k_r);
          end
        end
        k_nxt = k_r + CW'(1);
        state_nxt = (k_r + CW'(1) == n_w) ? S_DISP : S_EL_RD;
      end
      S_DISP: begin
        chosen_nxt = first_r;
        if (!any_r) begin
          status_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end else if (mode_r == MODE_SEQ) begin
          k_nxt     = '0;
          c_nxt     = cur_mod;
          state_nxt = S_SEQ;
        end else if (mode_r == MODE_SHUFFLE) begin
          k_nxt = '0;
          if (cur_r == '0 || cur_r >= n_w) begin
            shi_nxt = n_w;
            if (n_w > CW'(1)) begin
              state_nxt = S_DRAW;
            end else begin
              cur_nxt   = '0;
              state_nxt = S_SP_RD;
            end
          end else begin
            state_nxt = S_SP_RD;
          end
        end else if (total_r == '0) begin
          state_nxt = S_UPD_RD;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_SEQ: begin
        if (elig_r[IW'(c_r)]) begin
          chosen_nxt = IW'(c_r);
          cur_nxt    = c_inc;
          state_nxt  = S_UPD_RD;
        end else begin
          c_nxt = c_inc;
          k_nxt = k_r + CW'(1);
          if (k_r + CW'(1) == n_w) begin
            state_nxt = S_UPD_RD;
          end
        end
      end
      S_DRAW: begin
        rng_nxt   = xorshift(rng_r);
        state_nxt = S_M0;
      end
      S_M0: begin
        mul_a     = rng_r[31:0];
        mul_b     = RNG_MUL[31:0];
        state_nxt = S_M1;
      end
      S_M1: begin
        rand_nxt  = prod_r;
        mul_a     = rng_r[63:32];
        mul_b     = RNG_MUL[31:0];
        state_nxt = S_M2;
      end
      S_M2: begin
        rand_nxt[63:32] = rand_r[63:32] + prod_r[31:0];
        mul_a     = rng_r[31:0];
        mul_b     = RNG_MUL[63:32];
        state_nxt = S_M3;
      end
      S_M3: begin
        rand_nxt[63:32] = rand_r[63:32] + prod_r[31:0];
        if (mode_r == MODE_SHUFFLE) begin
          rem_nxt   = '0;
          dbit_nxt  = 6'd63;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_WT_M0;
        end
      end
      S_DIV: begin
        // restoring remainder, one dividend bit a cycle
        if (rem_sh >= 7'(shi_r)) begin
          rem_nxt = CW'(rem_sh - 7'(shi_r));
        end else begin
          rem_nxt = CW'(rem_sh);
        end
        dbit_nxt = dbit_r - 6'd1;
        if (dbit_r == 6'd0) begin
          j_nxt     = IW'(rem_nxt);
          state_nxt = S_SW_RA;
        end
      end
      S_SW_RA: begin
        ord_raddr = IW'(shi_r - CW'(1));
        state_nxt = S_SW_RB;
      end
      S_SW_RB: begin
        swa_nxt   = ord_vld_r[IW'(shi_r - CW'(1))] ? ord_rdata : IW'(shi_r - CW'(1));
        ord_raddr = j_r;
        state_nxt = S_SW_WA;
      end
      S_SW_WA: begin
        ord_we    = 1'b1;
        ord_waddr = IW'(shi_r - CW'(1));
        ord_wdata = ord_vld_r[j_r] ? ord_rdata : j_r;
        ord_vld_nxt[IW'(shi_r - CW'(1))] = 1'b1;
        state_nxt = S_SW_WB;
      end
      S_SW_WB: begin
        ord_we    = 1'b1;
        ord_waddr = j_r;
        ord_wdata = swa_r;
        ord_vld_nxt[j_r] = 1'b1;
        shi_nxt = shi_r - CW'(1);
        if (shi_r == CW'(2)) begin
          cur_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_SP_RD;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_SP_RD: begin
        ord_raddr = IW'(cur_mod);
        c_nxt     = cur_mod;
        state_nxt = S_SP_CHK;
      end
      S_SP_CHK: begin
        cur_nxt = cur_r + CW'(1);
        k_nxt   = k_r + CW'(1);
        if ((CW'(ov_w) < n_w) && elig_r[ov_w]) begin
          chosen_nxt = ov_w;
          state_nxt  = S_UPD_RD;
        end else if (k_r + CW'(1) == n_w) begin
          chosen_nxt = first_r;
          state_nxt  = S_UPD_RD;
        end else begin
          state_nxt = S_SP_RD;
        end
      end
      S_WT_M0: begin
        // low 32 bits of rand >> 11
        mul_a     = rand_r[42:11];
        mul_b     = 32'(total_r);
        state_nxt = S_WT_M1;
      end
      S_WT_M1: begin
        plohi_nxt = prod_r[63:32];
        mul_a     = 32'(rand_r[63:43]);
        mul_b     = 32'(total_r);
        state_nxt = S_WT_M2;
      end
      S_WT_M2: begin
        target_nxt = SUM_W'(tgt_sum >> 21);
        k_nxt      = '0;
        run_nxt    = '0;
        state_nxt  = S_WT_RD;
      end
      S_WT_RD: begin
        ent_raddr = IW'(k_r);
        state_nxt = S_WT_CHK;
      end
      S_WT_CHK: begin
        k_nxt = k_r + CW'(1);
        if (elig_r[IW'(k_r)]) begin
          run_nxt = run_sum;
        end
        if (elig_r[IW'(k_r)] && (run_sum > target_r)) begin
          chosen_nxt = IW'(k_r);
          state_nxt  = S_UPD_RD;
        end else if (k_r + CW'(1) == n_w) begin
          state_nxt = S_UPD_RD;
        end else begin
          state_nxt = S_WT_RD;
        end
      end
      S_UPD_RD: begin
        ent_raddr = chosen_r;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        // saturating frame + cooldown
        na_we    = 1'b1;
        na_waddr = chosen_r;
        na_wdata = upd_sum[64] ? {64{1'b1}} : upd_sum[63:0];
        na_vld_nxt[chosen_r] = 1'b1;
        last_nxt     = chosen_r;
        last_vld_nxt = 1'b1;
        status_nxt   = ST_CHOSEN;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = (status_r == ST_CHOSEN) ? 4'(chosen_r) : 4'd0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PICK_MODE: begin
          mode_nxt = cfg_data[1:0];
        end
        CFG_NO_REPEAT: begin
          norep_nxt = cfg_data[0];
        end
        CFG_ENTRY_COUNT: begin
          ecnt_nxt    = cfg_data[4:0];
          ord_vld_nxt = '0;
          cur_nxt     = '0;
        end
        CFG_SEED: begin
          rng_nxt = (cfg_data == 64'd0) ? RNG_DEFAULT : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
